// ===== sv/url_percent_decoder_utf8_defines.svh =====
// Assertion macros used by the URL percent decoder RTL.
// No dependencies; included by urld_back, which carries concurrent checks.
`ifndef URL_PERCENT_DECODER_UTF8_DEFINES_SVH
`define URL_PERCENT_DECODER_UTF8_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define URLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define URLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/urld_pkg.sv =====
// Shared types and constants of the URL percent decoder.
// No dependencies; imported by every decoder module.
package urld_pkg;

   // Characters with special meaning in the encoded stream
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_UPPER_U = 8'h55;

   // Job queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Escape parser phase
   typedef enum logic [2:0] {
      PH_TEXT = 3'd0,
      PH_PCT  = 3'd1,
      PH_HEX1 = 3'd2,
      PH_U0   = 3'd3,
      PH_U1   = 3'd4,
      PH_U2   = 3'd5,
      PH_U3   = 3'd6
   } phase_type;

   // One decoded request: up to three bytes plus end/error flags.
   // count 0 means a single result carrying no byte.
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            eos;
      logic            err;
   } job_type;

endpackage

// ===== sv/urld_front.sv =====
// Front end of the URL percent decoder: accepts requests, parses escapes,
// and pushes decoded jobs into the queue. Depends on urld_pkg.
module urld_front import urld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   input  logic       q_full,
   output logic       push,
   output job_type    push_job
);

   phase_type   phase_ff, phase_in, phase_nx;
   logic [15:0] acc_ff, acc_in, acc_nx;
   logic        abort_ff, abort_in, abort_nx;
   logic        accept;
   logic        is_digit;
   logic [3:0]  hex_val;
   logic [15:0] code;
   logic        is_u;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign push      = accept;

   // Hex digit value; non-digits map to (10 + lower(b) - 'a') mod 16
   assign is_digit = (req_in_byte >= 8'h30) && (req_in_byte <= 8'h39);
   assign hex_val  = is_digit ? req_in_byte[3:0] : (req_in_byte[3:0] + 4'd9);
   assign code     = {acc_ff[11:0], hex_val};
   assign is_u     = (req_in_byte == CH_LOWER_U) || (req_in_byte == CH_UPPER_U);

   // Next parser state
   always_comb begin
      phase_nx = phase_ff;
      acc_nx   = acc_ff;
      abort_nx = abort_ff;
      if (!abort_ff) begin
         unique case (phase_ff)
            PH_PCT: begin
               if (is_u) begin
                  acc_nx   = 16'd0;
                  phase_nx = PH_U0;
               end else if (req_in_byte[7]) begin
                  abort_nx = 1'b1;
                  phase_nx = PH_TEXT;
               end else begin
                  acc_nx   = {12'd0, hex_val};
                  phase_nx = PH_HEX1;
               end
            end
            PH_HEX1: begin
               if (req_in_byte[7]) abort_nx = 1'b1;
               phase_nx = PH_TEXT;
            end
            PH_U0: begin
               acc_nx   = code;
               phase_nx = PH_U1;
            end
            PH_U1: begin
               acc_nx   = code;
               phase_nx = PH_U2;
            end
            PH_U2: begin
               acc_nx   = code;
               phase_nx = PH_U3;
            end
            PH_U3: begin
               acc_nx   = 16'd0;
               phase_nx = PH_TEXT;
            end
            default: begin
               phase_nx = (req_in_byte == CH_PERCENT) ? PH_PCT : PH_TEXT;
            end
         endcase
      end
   end

   // End of string returns the parser to reset state
   always_comb begin
      if (req_end_of_string) begin
         phase_in = PH_TEXT;
         acc_in   = 16'd0;
         abort_in = 1'b0;
      end else begin
         phase_in = phase_nx;
         acc_in   = acc_nx;
         abort_in = abort_nx;
      end
   end

   // Decoded bytes for this request
   always_comb begin
      push_job       = '0;
      push_job.eos   = req_end_of_string;
      push_job.err   = abort_nx;
      if (!abort_ff) begin
         unique case (phase_ff)
            PH_PCT, PH_U0, PH_U1, PH_U2: begin
               push_job.count = 2'd0;
            end
            PH_HEX1: begin
               if (!req_in_byte[7]) begin
                  push_job.data[0] = {acc_ff[3:0], hex_val};
                  push_job.count   = 2'd1;
               end
            end
            PH_U3: begin
               if (code[15:7] == 9'd0) begin
                  push_job.data[0] = code[7:0];
                  push_job.count   = 2'd1;
               end else if (code[15:11] == 5'd0) begin
                  push_job.data[0] = {3'b110, code[10:6]};
                  push_job.data[1] = {2'b10, code[5:0]};
                  push_job.count   = 2'd2;
               end else begin
                  push_job.data[0] = {4'b1110, code[15:12]};
                  push_job.data[1] = {2'b10, code[11:6]};
                  push_job.data[2] = {2'b10, code[5:0]};
                  push_job.count   = 2'd3;
               end
            end
            default: begin
               if (req_in_byte == CH_PERCENT) begin
                  push_job.count = 2'd0;
               end else begin
                  push_job.data[0] = (req_in_byte == CH_PLUS) ? CH_SPACE : req_in_byte;
                  push_job.count   = 2'd1;
               end
            end
         endcase
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         acc_ff   <= 16'd0;
         abort_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         abort_ff <= abort_in;
      end
   end

endmodule

// ===== sv/urld_queue.sv =====
// Small job queue decoupling the decoder front from the output back end.
// Depends on urld_pkg.
module urld_queue import urld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_pop     = pop & head_valid;

   // Pointer and fill count updates
   always_comb begin
      wr_in  = push   ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !do_pop)      cnt_in = QCNT_W'(cnt_ff + 1'b1);
      else if (!push && do_pop) cnt_in = QCNT_W'(cnt_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

// ===== sv/urld_back.sv =====
// Back end of the URL percent decoder: expands queued jobs into one to
// three responses through an output register. Depends on urld_pkg.
`include "url_percent_decoder_utf8_defines.svh"
module urld_back import urld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end,
   output logic       rsp_decode_error
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       bvalid_ff, last_ff, send_ff, err_ff;
   logic [1:0] last_idx;
   logic       load;
   logic       is_last;

   // Expansion control: load a response whenever the output slot frees up
   assign last_idx = (head_job.count == 2'd0) ? 2'd0 : 2'(head_job.count - 2'd1);
   assign is_last  = (idx_ff == last_idx);
   assign load     = head_valid & (~valid_ff | ~rsp_stall);
   assign pop      = load & is_last;

   always_comb begin
      idx_in = idx_ff;
      if (load) idx_in = is_last ? 2'd0 : 2'(idx_ff + 2'd1);
      if (load)                       valid_in = 1'b1;
      else if (valid_ff && !rsp_stall) valid_in = 1'b0;
      else                            valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= (head_job.count == 2'd0) ? 8'd0 : head_job.data[idx_ff];
         bvalid_ff <= (head_job.count != 2'd0);
         last_ff   <= is_last;
         send_ff   <= is_last & head_job.eos;
         err_ff    <= head_job.err;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_string_end   = send_ff;
   assign rsp_decode_error = err_ff;

   `URLD_ASSERT_NOW(a_mid_has_byte, valid_ff && !last_ff, bvalid_ff, "non-final response without byte")
   `URLD_ASSERT_NOW(a_end_is_last, valid_ff && send_ff, last_ff, "string end not on last response")
   `URLD_ASSERT_NOW(a_expand_holds_head, idx_ff != 2'd0, head_valid, "expansion lost its job")
   `URLD_ASSERT_NEXT(a_fill_empty_slot, !valid_ff && head_valid, valid_ff, "queued job not sent")

endmodule

// ===== sv/url_percent_decoder_utf8.sv =====
// URL percent decoder with %u escapes to UTF-8: top level.
// Depends on urld_pkg, urld_front, urld_queue and urld_back.
//
// Usage: the request channel (req_valid / req_stall) carries one encoded
// byte per request with req_end_of_string marking the final byte of a
// string. Each request yields one to three responses on the rsp_ channel;
// rsp_run_last flags the last one of a request and rsp_string_end the last
// one of a string. A request that decodes to nothing yields one response
// with rsp_byte_valid low.
// The first response of a request passes through the job queue, written at
// the accepting edge, and then the output register.
// Throughput: one request per cycle while rsp_stall is low and each
// decodes to at most one byte; a %u escape expanding to N bytes gives
// N responses, absorbed by a four-entry job queue before req_stall rises.
// Reset clears the parser state, the queue and the output valid flag.
// When the receiver raises rsp_stall the response is held, the queue fills
// and then req_stall is asserted until room frees up.
module url_percent_decoder_utf8 import urld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end,
   output logic       rsp_decode_error
);

   logic    q_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   urld_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_full            (q_full),
      .push              (push),
      .push_job          (push_job)
   );

   urld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   urld_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_end   (rsp_string_end),
      .rsp_decode_error (rsp_decode_error)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for url_percent_decoder_utf8: a scoreboard class predicts
// the decoded bytes of every request. Directed and random strings are driven with stalls.
// Depends on urld_pkg and the url_percent_decoder_utf8 RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import urld_pkg::*;

   // ASCII codes used by the hex digit rule
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int SETTLE_CYCLES   = 8;

   typedef struct {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       str_end;
      logic       err;
   } decoded_type;

   // Predicts the decoder output and checks responses in order
   class decode_scoreboard;
      decoded_type decoded_q[$];
      phase_type   phase    = PH_TEXT;
      logic [15:0] accum    = '0;
      logic        aborted  = 1'b0;
      int          failures = 0;
      int          requests = 0;
      int          responses = 0;
      int          data_bytes = 0;
      int          strings  = 0;
      int          aborted_strings = 0;

      function int pending();
         return decoded_q.size();
      endfunction

      // Digits give their value; anything else maps through the letter rule
      function logic [3:0] hex_nibble(logic [7:0] b);
         logic [7:0] c;
         c = b;
         if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)
            return b[3:0];
         if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
            c = b + CASE_OFFSET;
         c = c + 8'd10 - CH_LOWER_A;
         return c[3:0];
      endfunction

      // Advance the parser on one accepted request and queue its responses
      function void note_request(logic [7:0] b, logic eos);
         logic [7:0]  out_bytes[3];
         logic [15:0] code;
         decoded_type item;
         int          n;
         int          count;
         n = 0;
         requests++;
         if (!aborted) begin
            case (phase)
               PH_PCT: begin
                  if (b == CH_LOWER_U || b == CH_UPPER_U) begin
                     accum = '0;
                     phase = PH_U0;
                  end else if (b[7]) begin
                     aborted = 1'b1;
                     phase = PH_TEXT;
                  end else begin
                     accum = {12'h000, hex_nibble(b)};
                     phase = PH_HEX1;
                  end
               end
               PH_HEX1: begin
                  if (b[7])
                     aborted = 1'b1;
                  else begin
                     out_bytes[0] = {accum[3:0], hex_nibble(b)};
                     n = 1;
                  end
                  phase = PH_TEXT;
               end
               PH_U0, PH_U1, PH_U2: begin
                  accum = {accum[11:0], hex_nibble(b)};
                  phase = phase_type'(phase + 3'd1);
               end
               PH_U3: begin
                  code = {accum[11:0], hex_nibble(b)};
                  // UTF-8 encoding of a 16-bit code point
                  if (code < 16'h0080) begin
                     out_bytes[0] = code[7:0];
                     n = 1;
                  end else if (code < 16'h0800) begin
                     out_bytes[0] = {3'b110, code[10:6]};
                     out_bytes[1] = {2'b10, code[5:0]};
                     n = 2;
                  end else begin
                     out_bytes[0] = {4'b1110, code[15:12]};
                     out_bytes[1] = {2'b10, code[11:6]};
                     out_bytes[2] = {2'b10, code[5:0]};
                     n = 3;
                  end
                  accum = '0;
                  phase = PH_TEXT;
               end
               default: begin
                  phase = PH_TEXT;
                  if (b == CH_PERCENT)
                     phase = PH_PCT;
                  else if (b == CH_PLUS) begin
                     out_bytes[0] = CH_SPACE;
                     n = 1;
                  end else begin
                     out_bytes[0] = b;
                     n = 1;
                  end
               end
            endcase
         end

         // A request with no decoded byte still yields one empty response
         count = (n > 0) ? n : 1;
         for (int k = 0; k < count; k++) begin
            item.data    = (n > 0) ? out_bytes[k] : 8'h00;
            item.valid   = (n > 0);
            item.last    = (k == count - 1);
            item.str_end = (k == count - 1) && eos;
            item.err     = aborted;
            decoded_q.push_back(item);
         end

         if (eos) begin
            phase   = PH_TEXT;
            accum   = '0;
            aborted = 1'b0;
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [7:0] data, logic valid, logic last,
                                   logic str_end, logic err);
         decoded_type want;
         if (decoded_q.size() == 0) begin
            $error("response 0x%0h arrived with no request outstanding", data);
            failures++;
            return;
         end
         want = decoded_q.pop_front();
         responses++;
         if (valid === 1'b1)
            data_bytes++;
         if (str_end === 1'b1) begin
            strings++;
            if (err === 1'b1)
               aborted_strings++;
         end
         compare_field("out_byte", want.data, data);
         compare_field("byte_valid", 8'(want.valid), 8'(valid));
         compare_field("run_last", 8'(want.last), 8'(last));
         compare_field("string_end", 8'(want.str_end), 8'(str_end));
         compare_field("decode_error", 8'(want.err), 8'(err));
      endfunction
   endclass

   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte       = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_string_end;
   logic       rsp_decode_error;

   decode_scoreboard sb;
   logic [7:0]       enc_text[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               items_sent    = 0;
   int               cycle_count   = 0;

   url_percent_decoder_utf8 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_end    (rsp_string_end),
      .rsp_decode_error  (rsp_decode_error)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Both handshakes are observed on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_out_byte, rsp_byte_valid, rsp_run_last,
                              rsp_string_end, rsp_decode_error);
         if (req_valid && !req_stall)
            sb.note_request(req_in_byte, req_end_of_string);
      end
   end

   // One request, with random idle cycles ahead of it
   task automatic send_request(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic eos);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], eos && (i == s.len() - 1));
   endtask

   task automatic send_string();
      for (int i = 0; i < enc_text.size(); i++)
         send_request(enc_text[i], i == enc_text.size() - 1);
   endtask

   // Hold off until every queued response has been seen
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10)
         return CH_DIGIT_0 + v;
      return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + v - 8'd10;
   endfunction

   // Mostly well-formed strings, with some malformed escapes and raw noise
   function void build_random_string();
      logic [7:0]  b;
      logic [15:0] code;
      int          pick;
      int          tail;
      enc_text.delete();
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(6, 1))
            enc_text.push_back(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(8, 1)) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // plain byte, mostly ASCII
            b = (pick < 25) ? 8'($urandom_range(127)) : 8'($urandom_range(255));
            if (b == CH_PERCENT)
               b = CH_PLUS;
            enc_text.push_back(b);
         end else if (pick < 40) begin
            enc_text.push_back(CH_PLUS);
         end else if (pick < 65) begin
            enc_text.push_back(CH_PERCENT);
            enc_text.push_back(hex_char(4'($urandom_range(15))));
            enc_text.push_back(hex_char(4'($urandom_range(15))));
         end else if (pick < 90) begin
            // %u with a code point sized for one, two or three UTF-8 bytes
            case ($urandom_range(2))
               0:       code = 16'($urandom_range(16'h007F, 16'h0000));
               1:       code = 16'($urandom_range(16'h07FF, 16'h0080));
               default: code = 16'($urandom_range(16'hFFFF, 16'h0800));
            endcase
            enc_text.push_back(CH_PERCENT);
            enc_text.push_back($urandom_range(1) ? CH_LOWER_U : CH_UPPER_U);
            enc_text.push_back(hex_char(code[15:12]));
            enc_text.push_back(hex_char(code[11:8]));
            enc_text.push_back(hex_char(code[7:4]));
            enc_text.push_back(hex_char(code[3:0]));
         end else if (pick < 95) begin
            // escape with arbitrary bytes, may abort the string
            enc_text.push_back(CH_PERCENT);
            enc_text.push_back(8'($urandom_range(255)));
            enc_text.push_back(8'($urandom_range(255)));
         end else begin
            enc_text.push_back(CH_PERCENT);
            enc_text.push_back(CH_LOWER_U);
            repeat (4)
               enc_text.push_back(8'($urandom_range(255)));
         end
      end
      // truncated escape at the end of the string
      if ($urandom_range(99) < 15) begin
         tail = $urandom_range(5);
         enc_text.push_back(CH_PERCENT);
         if (tail == 1)
            enc_text.push_back(hex_char(4'($urandom_range(15))));
         else if (tail >= 2) begin
            enc_text.push_back(CH_LOWER_U);
            repeat (tail - 2)
               enc_text.push_back(hex_char(4'($urandom_range(15))));
         end
      end
   endfunction

   initial begin
      sb = new;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 79;

      // zero byte, plus, two-digit escape
      send_request(8'h00, 1'b0);
      send_text("+%4a", 1'b1);
      // two-byte UTF-8, upper-case U, non-ASCII and non-hex %u digits
      send_text("%U07", 1'b0);
      send_request(8'h80, 1'b0);
      send_text("z", 1'b0);
      // three-byte UTF-8, mixed-case digits
      send_text("%uFfFf", 1'b1);
      // one-byte UTF-8 with 0xFF as a digit
      send_text("%u004", 1'b0);
      send_request(8'hFF, 1'b1);
      // truncated %u at end of string
      send_text("%u1", 1'b1);
      // non-ASCII hex position aborts, trailing byte ignored
      send_text("%", 1'b0);
      send_request(8'h80, 1'b0);
      send_text("A", 1'b1);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (items_sent < ITEMS_PER_PHASE * (p + 1)) begin
            build_random_string();
            send_string();
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests; checked %0d responses, %0d decoded bytes,",
               sb.requests, sb.responses, sb.data_bytes);
      $display("%0d strings (%0d aborted); plus, hex and %%u escapes, truncated escapes, stalls.",
               sb.strings, sb.aborted_strings);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
